@@ rtl/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// sli_pkg: shared types and codes for the sorted list block
// Operation codes, result status codes and the controller state type.
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 7;

   // request operation
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DELETED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

@@ rtl/sorted_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// sorted_list_insert_delete: bounded ascending table of signed 32-bit values
// Insert and delete requests walk a table memory with one read and one write port.
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY signed values in ascending order in one
// synchronous memory (one read and one write port, read data registered).
// An insert walks down from the last entry, moving each entry that is not
// smaller than the new value up by one slot, and drops the value into the
// gap just above the first entry that is smaller; so a new value lands
// ahead of any equal ones. A delete walks up from entry 0, finds the first
// equal entry and moves every later entry down one slot. Each request takes
// one read per visited entry, then passes the read pipeline and the finish
// state; an insert into a full table or a delete from an empty one skips the
// walk and goes straight to finish. The memory read port bounds the walk:
// one entry is visited per clock. Only one request is in flight; the next is
// taken once the result of the previous one sits in the output register.
// Every request gives exactly one result with the status and the entry count
// after the operation (the count's low 7 bits). Memory contents need no
// clearing after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic signed [sli_pkg::VALUE_W-1:0]  req_value,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sli_pkg::STATUS_W-1:0]        rsp_status,
   output logic [sli_pkg::COUNT_W-1:0]         rsp_entry_count
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   // table memory
   logic signed [sli_pkg::VALUE_W-1:0] mem [CAPACITY];
   logic signed [sli_pkg::VALUE_W-1:0] rd_data_ff;
   logic                               rd_en;
   logic [AW-1:0]                      rd_addr;
   logic                               wr_en;
   logic [AW-1:0]                      wr_addr;
   logic signed [sli_pkg::VALUE_W-1:0] wr_data;

   // control and request state
   sli_pkg::state_type                 state_ff, state_in;
   logic                               func_ff, func_in;
   logic signed [sli_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [CW-1:0]                      rem_ff, rem_in;      // reads still to issue
   logic [AW-1:0]                      idx_ff, idx_in;      // next read address
   logic                               pend_ff, pend_in;    // read data arrives now
   logic [AW-1:0]                      pidx_ff, pidx_in;    // address of that data
   logic                               found_ff, found_in;  // delete: match seen
   logic [sli_pkg::STATUS_W-1:0]       status_ff, status_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [sli_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [sli_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   assign req_ready       = (state_ff == sli_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // memory: one write, one registered read per cycle; writes in a walk
   // target entries already read or the free top slot, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      idx_in        = idx_ff;
      pidx_in       = pidx_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = pidx_ff;
      wr_data       = rd_data_ff;

      // result taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         sli_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               value_in = req_value;
               found_in = 1'b0;
               rem_in   = count_ff;
               if (req_func == sli_pkg::FUNC_INSERT) begin
                  idx_in = AW'(count_ff - CW'(1));
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = sli_pkg::STATUS_FULL;
                     state_in  = sli_pkg::ST_FINISH;
                  end else begin
                     state_in = sli_pkg::ST_WALK;
                  end
               end else begin
                  idx_in = '0;
                  if (count_ff == '0) begin
                     status_in = sli_pkg::STATUS_EMPTY;
                     state_in  = sli_pkg::ST_FINISH;
                  end else begin
                     state_in = sli_pkg::ST_WALK;
                  end
               end
            end
         end

         sli_pkg::ST_WALK: begin
            // issue side: one read per cycle
            if (rem_ff != '0) begin
               rd_en   = 1'b1;
               rem_in  = rem_ff - CW'(1);
               pidx_in = idx_ff;
               if (func_ff == sli_pkg::FUNC_INSERT) begin
                  idx_in = idx_ff - AW'(1);
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end

            // data side
            if (pend_ff) begin
               if (func_ff == sli_pkg::FUNC_INSERT) begin
                  wr_en   = 1'b1;
                  wr_addr = pidx_ff + AW'(1);
                  if (rd_data_ff < value_ff) begin
                     // smaller entry: new value goes right above it
                     wr_data   = value_ff;
                     count_in  = count_ff + CW'(1);
                     status_in = sli_pkg::STATUS_INSERTED;
                     state_in  = sli_pkg::ST_FINISH;
                  end
               end else if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = pidx_ff - AW'(1);
               end else if (rd_data_ff == value_ff) begin
                  found_in = 1'b1;
               end
            end else if (rem_ff == '0) begin
               // walk exhausted
               if (func_ff == sli_pkg::FUNC_INSERT) begin
                  wr_en     = 1'b1;
                  wr_addr   = '0;
                  wr_data   = value_ff;
                  count_in  = count_ff + CW'(1);
                  status_in = sli_pkg::STATUS_INSERTED;
               end else if (found_ff) begin
                  count_in  = count_ff - CW'(1);
                  status_in = sli_pkg::STATUS_DELETED;
               end else begin
                  status_in = sli_pkg::STATUS_NOT_FOUND;
               end
               state_in = sli_pkg::ST_FINISH;
            end
         end

         sli_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = sli_pkg::COUNT_W'(count_ff);
               state_in      = sli_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sli_pkg::ST_IDLE;
         end
      endcase

      pend_in = rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sli_pkg::ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      rem_ff        <= rem_in;
      idx_ff        <= idx_in;
      pidx_ff       <= pidx_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

`ifndef SYNTHESIS
   // the count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // walk writes stay inside the occupied part of the table (plus one slot)
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("table write beyond stored entries");

   // a full insert, an empty delete or a delete with no match must not change the count
   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sli_pkg::ST_FINISH &&
       (status_ff == sli_pkg::STATUS_FULL || status_ff == sli_pkg::STATUS_EMPTY ||
        status_ff == sli_pkg::STATUS_NOT_FOUND) && $past(state_ff == sli_pkg::ST_FINISH))
      |-> $stable(count_ff))
      else $error("count changed on refused request");

   // an accepted request always leaves idle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != sli_pkg::ST_IDLE))
      else $error("request accepted but controller stayed idle");
`endif

endmodule
